[hw/rtl/fpbc_pkg.sv]
// Shared types and constants for the FIFO page buffer cache.
`default_nettype none
package fpbc_pkg;
	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int SLOT_W    = 12;
	localparam int SLOT_BITS = 12;
	localparam int ADDR_W    = 56;
	localparam int CNT_W     = 32;
	localparam int VCNT_W    = 7;
	localparam int QDEPTH    = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] page_addr;
	} in_word_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] found_addr;
		logic              evicted;
		logic [ADDR_W-1:0] evicted_addr;
		logic [CNT_W-1:0]  hit_total;
		logic [CNT_W-1:0]  miss_total;
		logic [VCNT_W-1:0] valid_total;
	} out_word_t;

	typedef struct packed {
		op_t                  op;
		logic [SLOT_BITS-1:0] tag;
		logic [ADDR_W-1:0]    addr;
	} q_word_t;

	typedef struct packed {
		logic    valid;
		q_word_t word;
	} q_req_t;
endpackage
`default_nettype wire

[hw/rtl/fifo_page_buffer_cache.sv]
// Top level of the FIFO page buffer cache.
// A 64-entry fully associative cache from swap slot to page address. An insert word
// writes the entry under a round-robin hand and reports the old address if that entry
// was valid; a lookup word takes the lowest-numbered valid entry with the same slot,
// returns its address and frees it. Every word gives one result that carries the hit,
// miss and valid-entry counts. Words enter a two-deep queue; the execute unit takes a
// new word only after the previous one has left its stage-one registers (tag match,
// entry update and address read), and forms the result in the result register, which
// drives rsp_valid. All entries come up invalid after reset; no clearing pass is needed.
`default_nettype none
module fifo_page_buffer_cache (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  fpbc_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output fpbc_pkg::out_word_t rsp
);
	fpbc_pkg::q_req_t q_req;
	logic             q_pop;

	fpbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_req     (q_req),
		.q_pop     (q_pop)
	);

	fpbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

[hw/rtl/fpbc_front.sv]
// Front end: accepts request words, decodes the action and queues them.
`default_nettype none
module fpbc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  fpbc_pkg::in_word_t  req,
	output fpbc_pkg::q_req_t    q_req,
	input  wire                 q_pop
);
	localparam int PTR_W = $clog2(fpbc_pkg::QDEPTH);

	fpbc_pkg::q_word_t      slots_q [fpbc_pkg::QDEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         fill_q;
	logic                   push;
	logic                   pop;
	fpbc_pkg::q_word_t      dec;

	always_comb begin
		dec.op   = req.action ? fpbc_pkg::OP_LOOKUP : fpbc_pkg::OP_INSERT;
		dec.tag  = req.slot[fpbc_pkg::SLOT_BITS-1:0];
		dec.addr = req.page_addr;
	end

	assign req_stall   = (fill_q == (PTR_W+1)'(fpbc_pkg::QDEPTH));
	assign push        = req_valid && !req_stall;
	assign pop         = q_pop && q_req.valid;
	assign q_req.valid = (fill_q != '0);
	assign q_req.word  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fpbc_pkg::QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fpbc_pkg::QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/fpbc_back.sv]
// Back end: tag match, entry store, counters and the result register.
`default_nettype none
module fpbc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fpbc_pkg::q_req_t    q_req,
	output logic                q_pop,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output fpbc_pkg::out_word_t rsp
);
	localparam int IW = fpbc_pkg::IDX_W;

	logic [fpbc_pkg::ENTRIES-1:0]   valid_q;
	logic [fpbc_pkg::SLOT_BITS-1:0] tag_q    [fpbc_pkg::ENTRIES];
	logic [fpbc_pkg::ADDR_W-1:0]    addr_mem [fpbc_pkg::ENTRIES];
	logic [IW-1:0]                  hand_q;
	logic [fpbc_pkg::VCNT_W-1:0]    count_q;
	logic [fpbc_pkg::CNT_W-1:0]     hits_q;
	logic [fpbc_pkg::CNT_W-1:0]     misses_q;

	logic                           s1_valid_q;
	logic                           hit_s1;
	logic                           evict_s1;
	logic [fpbc_pkg::ADDR_W-1:0]    rdata_s1;

	logic                           rsp_valid_q;
	fpbc_pkg::out_word_t            rsp_q;

	logic [fpbc_pkg::ENTRIES-1:0]   match;
	logic                           match_any;
	logic [IW-1:0]                  match_idx;
	logic                           is_ins;
	logic [IW-1:0]                  rd_idx;
	logic                           advance;

	always_comb begin
		match_idx = '0;
		for (int i = fpbc_pkg::ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == q_req.word.tag);
			if (match[i]) begin
				match_idx = IW'(i);
			end
		end
	end

	assign match_any = |match;
	assign is_ins    = (q_req.word.op == fpbc_pkg::OP_INSERT);
	assign rd_idx    = is_ins ? hand_q : match_idx;
	assign q_pop     = q_req.valid && !s1_valid_q;
	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_s1 <= addr_mem[rd_idx];
			hit_s1   <= !is_ins && match_any;
			evict_s1 <= is_ins && valid_q[hand_q];
			if (is_ins) begin
				addr_mem[hand_q] <= q_req.word.addr;
				tag_q[hand_q]    <= q_req.word.tag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.hit          <= hit_s1;
			rsp_q.found_addr   <= hit_s1 ? rdata_s1 : '0;
			rsp_q.evicted      <= evict_s1;
			rsp_q.evicted_addr <= evict_s1 ? rdata_s1 : '0;
			rsp_q.hit_total    <= hits_q;
			rsp_q.miss_total   <= misses_q;
			rsp_q.valid_total  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hand_q      <= '0;
			count_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (is_ins) begin
					valid_q[hand_q] <= 1'b1;
					if (!valid_q[hand_q]) begin
						count_q <= count_q + 1'b1;
					end
					hand_q <= (hand_q == IW'(fpbc_pkg::ENTRIES-1)) ? '0 : hand_q + 1'b1;
				end else if (match_any) begin
					valid_q[match_idx] <= 1'b0;
					count_q            <= count_q - 1'b1;
					hits_q             <= hits_q + 1'b1;
				end else begin
					misses_q <= misses_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/fpbc_checker.sv]
// Port-level checks for the FIFO page buffer cache, bound to the top level.
`default_nettype none
module fpbc_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 req_valid,
	input wire                 req_stall,
	input fpbc_pkg::in_word_t  req,
	input wire                 rsp_valid,
	input wire                 rsp_stall,
	input fpbc_pkg::out_word_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted))
		else $error("result shows both hit and eviction");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_addr == '0)
		else $error("found address nonzero without hit");

	a_valid_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.valid_total <= fpbc_pkg::VCNT_W'(fpbc_pkg::ENTRIES))
		else $error("valid count above entry count");
endmodule

bind fifo_page_buffer_cache fpbc_checker u_fpbc_checker (.*);
`default_nettype wire

[tb/sv/fifo_page_buffer_cache_tb.sv]
`timescale 1ns / 100ps
// Testbench for fifo_page_buffer_cache: directed and random words checked against a cache model.
module fifo_page_buffer_cache_tb;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [fpbc_pkg::ADDR_W-1:0] ADDR_MAX = '1;
	localparam logic [fpbc_pkg::ADDR_W-1:0] ADDR_ONE = fpbc_pkg::ADDR_W'(1);
	localparam logic [fpbc_pkg::SLOT_W-1:0] SLOT_MAX = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	fpbc_pkg::in_word_t  req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	fpbc_pkg::out_word_t rsp;

	int req_idle_pct = 32;
	int rsp_stall_pct = 32;
	int hold_left = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	// cache model state
	logic                           ent_valid [fpbc_pkg::ENTRIES];
	logic [fpbc_pkg::SLOT_BITS-1:0] ent_tag [fpbc_pkg::ENTRIES];
	logic [fpbc_pkg::ADDR_W-1:0]    ent_addr [fpbc_pkg::ENTRIES];
	logic [fpbc_pkg::IDX_W-1:0]     hand = '0;
	logic [fpbc_pkg::VCNT_W-1:0]    valid_cnt = '0;
	logic [fpbc_pkg::CNT_W-1:0]     hit_cnt = '0;
	logic [fpbc_pkg::CNT_W-1:0]     miss_cnt = '0;
	fpbc_pkg::out_word_t            pending_rsp [$];

	fifo_page_buffer_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic fpbc_pkg::out_word_t cache_step(fpbc_pkg::in_word_t w);
		fpbc_pkg::out_word_t            r;
		logic [fpbc_pkg::SLOT_BITS-1:0] tag;
		r = '0;
		tag = w.slot[fpbc_pkg::SLOT_BITS-1:0];
		if (fpbc_pkg::op_t'(w.action) == fpbc_pkg::OP_INSERT) begin
			if (ent_valid[hand]) begin
				r.evicted = 1'b1;
				r.evicted_addr = ent_addr[hand];
				valid_cnt--;
			end
			ent_valid[hand] = 1'b1;
			ent_tag[hand] = tag;
			ent_addr[hand] = w.page_addr;
			valid_cnt++;
			hand++;
		end else begin
			// lowest-numbered match wins
			for (int i = 0; i < fpbc_pkg::ENTRIES; i++) begin
				if (!r.hit && ent_valid[i] && ent_tag[i] == tag) begin
					r.hit = 1'b1;
					r.found_addr = ent_addr[i];
					ent_valid[i] = 1'b0;
					valid_cnt--;
				end
			end
			if (r.hit)
				hit_cnt++;
			else
				miss_cnt++;
		end
		r.hit_total = hit_cnt;
		r.miss_total = miss_cnt;
		r.valid_total = valid_cnt;
		return r;
	endfunction

	function automatic fpbc_pkg::in_word_t make_word(fpbc_pkg::op_t op,
			logic [fpbc_pkg::SLOT_W-1:0] slot, logic [fpbc_pkg::ADDR_W-1:0] addr);
		fpbc_pkg::in_word_t w;
		w.action = op;
		w.slot = slot;
		w.page_addr = addr;
		return w;
	endfunction

	function automatic logic [fpbc_pkg::SLOT_W-1:0] pick_slot();
		case ($urandom_range(9))
			0: return fpbc_pkg::SLOT_W'($urandom);
			1: return SLOT_MAX - fpbc_pkg::SLOT_W'($urandom_range(3));
			default: return fpbc_pkg::SLOT_W'($urandom_range(47));
		endcase
	endfunction

	function automatic logic [fpbc_pkg::ADDR_W-1:0] pick_addr();
		logic [fpbc_pkg::ADDR_W-1:0] a;
		case ($urandom_range(19))
			0: a = ADDR_MAX;
			1: a = ADDR_ONE;
			default: a = fpbc_pkg::ADDR_W'({$urandom, $urandom});
		endcase
		if (a == '0)
			a = ADDR_ONE;
		return a;
	endfunction

	function automatic fpbc_pkg::in_word_t random_word(int insert_pct);
		fpbc_pkg::op_t op;
		op = ($urandom_range(99) < insert_pct) ? fpbc_pkg::OP_INSERT : fpbc_pkg::OP_LOOKUP;
		return make_word(op, pick_slot(), pick_addr());
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	task automatic send_word(fpbc_pkg::in_word_t w);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(cache_step(w));
	endtask

	task automatic test_empty_lookup();
		send_word(make_word(fpbc_pkg::OP_LOOKUP, '0, ADDR_MAX));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, SLOT_MAX, ADDR_ONE));
	endtask

	task automatic test_insert_lookup();
		send_word(make_word(fpbc_pkg::OP_INSERT, '0, ADDR_ONE));
		send_word(make_word(fpbc_pkg::OP_INSERT, SLOT_MAX, ADDR_MAX));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, SLOT_MAX, ADDR_ONE));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, '0, ADDR_MAX));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, '0, ADDR_ONE));
	endtask

	task automatic test_duplicate_slots();
		send_word(make_word(fpbc_pkg::OP_INSERT, 12'd7, 56'h11));
		send_word(make_word(fpbc_pkg::OP_INSERT, 12'd7, 56'h22));
		send_word(make_word(fpbc_pkg::OP_INSERT, 12'd7, 56'h33));
		repeat (4)
			send_word(make_word(fpbc_pkg::OP_LOOKUP, 12'd7, ADDR_ONE));
	endtask

	task automatic test_bit_patterns();
		send_word(make_word(fpbc_pkg::OP_INSERT, 12'hAAA, 56'hAA_AAAA_AAAA_AAAA));
		send_word(make_word(fpbc_pkg::OP_INSERT, 12'h555, 56'h55_5555_5555_5555));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, 12'h555, 56'hAA_AAAA_AAAA_AAAA));
		send_word(make_word(fpbc_pkg::OP_LOOKUP, 12'hAAA, 56'h55_5555_5555_5555));
	endtask

	task automatic test_random(int count, int insert_pct);
		repeat (count)
			send_word(random_word(insert_pct));
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_backpressure();
		req_idle_pct = 0;
		hold_left = 300;
		test_random(40, 60);
		req_idle_pct = 32;
	endtask

	task automatic test_no_idle();
		req_idle_pct = 0;
		rsp_stall_pct = 0;
		test_random(250, 55);
		req_idle_pct = 32;
		rsp_stall_pct = 32;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin : rsp_check
		fpbc_pkg::out_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("result word with no request pending");
				fail_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("hit", want.hit, rsp.hit);
				check_field("found_addr", want.found_addr, rsp.found_addr);
				check_field("evicted", want.evicted, rsp.evicted);
				check_field("evicted_addr", want.evicted_addr, rsp.evicted_addr);
				check_field("hit_total", want.hit_total, rsp.hit_total);
				check_field("miss_total", want.miss_total, rsp.miss_total);
				check_field("valid_total", want.valid_total, rsp.valid_total);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		foreach (ent_valid[i])
			ent_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookup();
		test_insert_lookup();
		test_duplicate_slots();
		test_bit_patterns();
		test_random(300, 80);
		test_random(300, 25);
		test_backpressure();
		test_no_idle();
		test_random(280, 85);
		test_random(280, 30);
		test_random(280, 50);

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
